[src/integer_matrix_multiply_assert.svh]
`ifndef INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define IMM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/imm_pkg.sv]
package imm_pkg;

   localparam int MAX_DIM_DEFAULT = 8;
   localparam int DATA_W = 32;
   localparam int IDX_W = 3;
   localparam int DIM_W = 4;
   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef enum logic [1:0] {
      REQ_LOAD_A  = 2'd0,
      REQ_LOAD_B  = 2'd1,
      REQ_COMPUTE = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_ROWS_A    = 2'd0,
      CSR_INNER_DIM = 2'd1,
      CSR_COLS_B    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ISSUE = 2'd1,
      ST_FLUSH = 2'd2
   } state_type;

   // one multiply-accumulate step handed to the shared unit
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic clear_done;
   } issue_type;

   typedef struct packed {
      logic done;
   } mac_stat_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last;
   } emit_type;

   // last loop index for a dimension register: zero acts as one, large values saturate
   function automatic int clamp_last(logic [DIM_W-1:0] d, int max_dim);
      int v;
      v = int'(d);
      if (v == 0) begin
         return 0;
      end
      if (v > max_dim) begin
         return max_dim - 1;
      end
      return v - 1;
   endfunction

endpackage

[src/integer_matrix_multiply.sv]
// Signed 32-bit matrix multiplier. Load transactions (req_type 0 for A, 1 for B) write one
// element at (req_row, req_col) and are accepted while idle; indices at or beyond MAX_DIM are
// dropped, and type 3 is ignored. A compute transaction (req_type 2) returns the
// rows_a x cols_b product in row-major order, one rsp transaction per element with rsp_last
// on the final one; sums wrap modulo 2^32. Every product element goes through the single
// multiply-accumulate unit, one term per cycle from one read port on each store; req_ready
// stays low for the whole compute, also while the result side holds rsp_ready low. Dimension
// registers of 0 act as 1 and saturate at MAX_DIM. Write configuration only while the
// block is idle; every element used by a compute must have been loaded first.
`include "integer_matrix_multiply_assert.svh"

module integer_matrix_multiply #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [imm_pkg::IDX_W-1:0]   req_row,
   input  logic [imm_pkg::IDX_W-1:0]   req_col,
   input  logic signed [imm_pkg::DATA_W-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [imm_pkg::IDX_W-1:0]   rsp_out_row,
   output logic [imm_pkg::IDX_W-1:0]   rsp_out_col,
   output logic signed [imm_pkg::DATA_W-1:0] rsp_product_value,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [imm_pkg::DIM_W-1:0]   csr_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW = (DEPTH < 2) ? 1 : $clog2(DEPTH);

   logic [imm_pkg::DIM_W-1:0] rows_a_ff, rows_a_in;
   logic [imm_pkg::DIM_W-1:0] inner_dim_ff, inner_dim_in;
   logic [imm_pkg::DIM_W-1:0] cols_b_ff, cols_b_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [imm_pkg::IDX_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [imm_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic rsp_last_ff, rsp_last_in;
   logic out_free;

   imm_pkg::issue_type    issue;
   imm_pkg::emit_type     emit;
   imm_pkg::mac_stat_type mac_stat;
   logic wr_a_en, wr_b_en;
   logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
   logic [imm_pkg::DATA_W-1:0] wr_data, a_data, b_data, acc_value;

   assign csr_ready = 1'b1;

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_dim_in = inner_dim_ff;
      cols_b_in    = cols_b_ff;
      if (csr_valid) begin
         unique case (imm_pkg::csr_index_type'(csr_index))
            imm_pkg::CSR_ROWS_A:    rows_a_in    = csr_data;
            imm_pkg::CSR_INNER_DIM: inner_dim_in = csr_data;
            imm_pkg::CSR_COLS_B:    cols_b_in    = csr_data;
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // output register: load on emit, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = emit.row;
         rsp_col_in   = emit.col;
         rsp_value_in = acc_value;
         rsp_last_in  = emit.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= imm_pkg::DIM_RESET;
         inner_dim_ff <= imm_pkg::DIM_RESET;
         cols_b_ff    <= imm_pkg::DIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_a_ff    <= rows_a_in;
         inner_dim_ff <= inner_dim_in;
         cols_b_ff    <= cols_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;

   imm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_row   (req_row),
      .req_col   (req_col),
      .req_value (req_value),
      .rows_a    (rows_a_ff),
      .inner_dim (inner_dim_ff),
      .cols_b    (cols_b_ff),
      .out_free  (out_free),
      .mac_stat  (mac_stat),
      .issue     (issue),
      .emit      (emit),
      .wr_a_en   (wr_a_en),
      .wr_b_en   (wr_b_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr)
   );

   imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_a_addr),
      .rd_data (a_data)
   );

   imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_b_addr),
      .rd_data (b_data)
   );

   imm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .a_data    (a_data),
      .b_data    (b_data),
      .stat      (mac_stat),
      .acc_value (acc_value)
   );

   `IMM_ASSERT_NOW(a_emit_into_free, emit.valid, !rsp_valid_ff || rsp_ready, "result overwritten before it was taken")
   `IMM_ASSERT_NOW(a_issue_vs_done, issue.valid, !mac_stat.done, "new term issued while a sum waits")
   `IMM_ASSERT_NEXT(a_compute_busy, req_valid && req_ready && req_type == imm_pkg::REQ_COMPUTE, !req_ready, "ready while computing")

endmodule

[src/imm_ram.sv]
module imm_ram #(
   parameter int WIDTH = imm_pkg::DATA_W,
   parameter int DEPTH = imm_pkg::MAX_DIM_DEFAULT * imm_pkg::MAX_DIM_DEFAULT,
   localparam int AW = (DEPTH < 2) ? 1 : $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/imm_mac.sv]
module imm_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  imm_pkg::issue_type          issue,
   input  logic [imm_pkg::DATA_W-1:0]  a_data,
   input  logic [imm_pkg::DATA_W-1:0]  b_data,
   output imm_pkg::mac_stat_type       stat,
   output logic [imm_pkg::DATA_W-1:0]  acc_value
);

   // stage 1: memory read data valid
   logic s1_valid_ff, s1_first_ff, s1_last_ff;
   // stage 2: product registered
   logic s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [imm_pkg::DATA_W-1:0] prod_ff, prod_in;
   logic [imm_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic done_ff, done_in;

   // low word of the product is the same for signed and unsigned operands
   assign prod_in = a_data * b_data;

   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         acc_in = s2_first_ff ? prod_ff : acc_ff + prod_ff;
      end
   end

   always_comb begin
      done_in = done_ff;
      if (s2_valid_ff && s2_last_ff) begin
         done_in = 1'b1;
      end else if (issue.clear_done) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= issue.valid;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= done_in;
      end
      s1_first_ff <= issue.first;
      s1_last_ff  <= issue.last;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
   end

   assign stat.done = done_ff;
   assign acc_value = acc_ff;

endmodule

[src/imm_seq.sv]
module imm_seq #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT,
   localparam int DEPTH = MAX_DIM * MAX_DIM,
   localparam int AW = (DEPTH < 2) ? 1 : $clog2(DEPTH),
   localparam int CW = (MAX_DIM > 16) ? 4 : ((MAX_DIM < 2) ? 1 : $clog2(MAX_DIM))
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [imm_pkg::IDX_W-1:0]   req_row,
   input  logic [imm_pkg::IDX_W-1:0]   req_col,
   input  logic [imm_pkg::DATA_W-1:0]  req_value,
   input  logic [imm_pkg::DIM_W-1:0]   rows_a,
   input  logic [imm_pkg::DIM_W-1:0]   inner_dim,
   input  logic [imm_pkg::DIM_W-1:0]   cols_b,
   input  logic                        out_free,
   input  imm_pkg::mac_stat_type       mac_stat,
   output imm_pkg::issue_type          issue,
   output imm_pkg::emit_type           emit,
   output logic                        wr_a_en,
   output logic                        wr_b_en,
   output logic [AW-1:0]               wr_addr,
   output logic [imm_pkg::DATA_W-1:0]  wr_data,
   output logic [AW-1:0]               rd_a_addr,
   output logic [AW-1:0]               rd_b_addr
);

   imm_pkg::state_type state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CW-1:0] n_last_ff, n_last_in, m_last_ff, m_last_in, p_last_ff, p_last_in;
   logic accept, in_range, start, k_end, j_end, i_end, flush_go;

   assign accept   = req_valid && req_ready;
   assign in_range = (int'(req_row) < MAX_DIM) && (int'(req_col) < MAX_DIM);
   assign start    = accept && (req_type == imm_pkg::REQ_COMPUTE);
   assign k_end    = (k_ff == m_last_ff);
   assign j_end    = (j_ff == p_last_ff);
   assign i_end    = (i_ff == n_last_ff);
   assign flush_go = (state_ff == imm_pkg::ST_FLUSH) && mac_stat.done && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = imm_pkg::ST_ISSUE;
            end
         end
         imm_pkg::ST_ISSUE: begin
            if (k_end) begin
               state_in = imm_pkg::ST_FLUSH;
            end
         end
         imm_pkg::ST_FLUSH: begin
            if (flush_go) begin
               state_in = (i_end && j_end) ? imm_pkg::ST_IDLE : imm_pkg::ST_ISSUE;
            end
         end
         default: state_in = imm_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready        = 1'b0;
      wr_a_en          = 1'b0;
      wr_b_en          = 1'b0;
      issue.valid      = 1'b0;
      issue.first      = 1'b0;
      issue.last       = 1'b0;
      issue.clear_done = 1'b0;
      emit.valid       = 1'b0;
      emit.row         = imm_pkg::IDX_W'(i_ff);
      emit.col         = imm_pkg::IDX_W'(j_ff);
      emit.last        = i_end && j_end;
      unique case (state_ff)
         imm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            unique case (imm_pkg::req_kind_type'(req_type))
               imm_pkg::REQ_LOAD_A: wr_a_en = req_valid && in_range;
               imm_pkg::REQ_LOAD_B: wr_b_en = req_valid && in_range;
               default: ;
            endcase
         end
         imm_pkg::ST_ISSUE: begin
            issue.valid = 1'b1;
            issue.first = (k_ff == '0);
            issue.last  = k_end;
         end
         imm_pkg::ST_FLUSH: begin
            emit.valid       = flush_go;
            issue.clear_done = flush_go;
         end
         default: ;
      endcase
   end

   // loop counters and latched dimensions
   always_comb begin
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      n_last_in = n_last_ff;
      m_last_in = m_last_ff;
      p_last_in = p_last_ff;
      if (start) begin
         i_in      = '0;
         j_in      = '0;
         k_in      = '0;
         n_last_in = CW'(imm_pkg::clamp_last(rows_a, MAX_DIM));
         m_last_in = CW'(imm_pkg::clamp_last(inner_dim, MAX_DIM));
         p_last_in = CW'(imm_pkg::clamp_last(cols_b, MAX_DIM));
      end else if (state_ff == imm_pkg::ST_ISSUE) begin
         k_in = k_end ? '0 : k_ff + 1'b1;
      end else if (flush_go) begin
         if (j_end) begin
            j_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      n_last_ff <= n_last_in;
      m_last_ff <= m_last_in;
      p_last_ff <= p_last_in;
   end

   assign wr_addr   = AW'(int'(req_row) * MAX_DIM + int'(req_col));
   assign wr_data   = req_value;
   assign rd_a_addr = AW'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign rd_b_addr = AW'(int'(k_ff) * MAX_DIM + int'(j_ff));

endmodule
